[design/pbe_pkg.sv]
package pbe_pkg;

    localparam int ID_W      = 16;
    localparam int TIME_W    = 32;
    localparam int CTR_W     = 32;
    localparam int DEV_OUT_W = 3;
    localparam int CNT_OUT_W = 5;
    localparam int AD_W      = 4;
    localparam int QL_W      = 5;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CLS_W     = 2;
    localparam int STAT_W    = 2;

    localparam logic [AD_W-1:0] AD_RESET = 4'd1;
    localparam logic [QL_W-1:0] QL_RESET = 5'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_DEVICES = 1'b0,
        CFG_QUEUE_LIMIT    = 1'b1
    } cfg_idx_t;

    typedef logic [CLS_W-1:0] cls_t;
    localparam cls_t CLS_CORP = 2'd0;
    localparam cls_t CLS_PREM = 2'd1;
    localparam cls_t CLS_FREE = 2'd2;

    typedef logic [STAT_W-1:0] stat_t;
    localparam stat_t ST_QUEUED   = 2'd0;
    localparam stat_t ST_EVICTED  = 2'd1;
    localparam stat_t ST_REJECTED = 2'd2;
    localparam stat_t ST_FINISH   = 2'd3;

    localparam logic REQ_ARRIVE = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

endpackage

[design/priority_buffer_with_eviction_core.sv]
// Channel   Direction  Handshake            Word
// in        sink       in_valid / in_stall  req_type req_class req_id event_time device_index
// out       source     out_valid/out_stall  admit_status evicted_* dispatch_* wait_time counters
// cfg       sink       cfg_write            cfg_index cfg_data
//
// An arrival steps from accept through decide and then reject, or evict if needed, insert and
// dispatch; a finish event goes straight to dispatch. A dispatch adds a served step before done.
// One shared 32-bit adder handles wait times and the rejected and served counter updates in turn.
// in_stall is high from accept until the result moves into the output register.
// The output register holds a result while out_stall is high; the next word is
// accepted meanwhile. Reset clears the queue count, servers and counters.
module priority_buffer_with_eviction_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int DEVICES     = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            req_type,
    input  logic [pbe_pkg::CLS_W-1:0]       req_class,
    input  logic [pbe_pkg::ID_W-1:0]        req_id,
    input  logic [pbe_pkg::TIME_W-1:0]      event_time,
    input  logic [2:0]                      device_index,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [pbe_pkg::STAT_W-1:0]      admit_status,
    output logic                            evicted_valid,
    output logic [pbe_pkg::ID_W-1:0]        evicted_id,
    output logic                            dispatch_valid,
    output logic [pbe_pkg::ID_W-1:0]        dispatch_id,
    output logic [pbe_pkg::DEV_OUT_W-1:0]   dispatch_device,
    output logic [pbe_pkg::TIME_W-1:0]      wait_time,
    output logic [pbe_pkg::CTR_W-1:0]       rejected_corporate,
    output logic [pbe_pkg::CTR_W-1:0]       rejected_premium,
    output logic [pbe_pkg::CTR_W-1:0]       rejected_free,
    output logic [pbe_pkg::CTR_W-1:0]       served_count,
    output logic [pbe_pkg::CNT_OUT_W-1:0]   queue_count,
    input  logic                            cfg_write,
    input  logic [pbe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pbe_pkg::CFG_W-1:0]       cfg_data
);

    import pbe_pkg::*;

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int DEV_W  = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int DEVN_W = $clog2(DEVICES + 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECIDE = 8'b0000_0010,
        S_EVICT  = 8'b0000_0100,
        S_INSERT = 8'b0000_1000,
        S_REJECT = 8'b0001_0000,
        S_DISP   = 8'b0010_0000,
        S_SERVED = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t                 state_reg, state_next;
    logic [AD_W-1:0]        ad_reg;
    logic [QL_W-1:0]        ql_reg;

    logic [ID_W-1:0]        id_reg [QUEUE_DEPTH];
    logic [TIME_W-1:0]      tm_reg [QUEUE_DEPTH];

    logic [CNT_W-1:0]       total_reg, total_next;
    logic [CNT_W-1:0]       cnt_reg [3];
    logic [CNT_W-1:0]       cnt_next [3];
    logic [DEVICES-1:0]     busy_reg, busy_next;
    logic [CTR_W-1:0]       rej_reg [3];
    logic [CTR_W-1:0]       rej_next [3];
    logic [CTR_W-1:0]       served_reg, served_next;

    cls_t                   cls_reg, cls_next;
    cls_t                   ev_cls_reg, ev_cls_next;
    logic [ID_W-1:0]        nid_reg;
    logic [TIME_W-1:0]      now_reg;
    logic [CNT_W-1:0]       k_reg, k_next;

    stat_t                  stat_reg, stat_next;
    logic                   evv_reg, evv_next;
    logic [ID_W-1:0]        evid_reg, evid_next;
    logic                   dv_reg, dv_next;
    logic [ID_W-1:0]        did_reg, did_next;
    logic [DEV_W-1:0]       ddev_reg, ddev_next;
    logic [TIME_W-1:0]      wait_reg, wait_next;

    logic                   out_valid_reg, out_valid_next;
    stat_t                  o_stat_reg;
    logic                   o_evv_reg;
    logic [ID_W-1:0]        o_evid_reg;
    logic                   o_dv_reg;
    logic [ID_W-1:0]        o_did_reg;
    logic [DEV_W-1:0]       o_ddev_reg;
    logic [TIME_W-1:0]      o_wait_reg;
    logic [CTR_W-1:0]       o_rej_reg [3];
    logic [CTR_W-1:0]       o_served_reg;
    logic [CNT_W-1:0]       o_total_reg;

    logic                   accept;
    logic                   load_out;
    logic [CNT_W-1:0]       lim_eff;
    logic [DEVN_W-1:0]      srv_n;
    logic                   srv_found;
    logic [DEV_W-1:0]       srv_sel;
    logic [CNT_W-1:0]       pos;
    logic [CNT_W-1:0]       n01;
    logic [CNT_W-1:0]       k_sel;
    cls_t                   head_cls;
    logic                   do_remove, do_insert;
    logic [CNT_W-1:0]       rm_at;

    logic [CTR_W-1:0]       alu_a, alu_b, alu_sum;
    logic                   alu_cin;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        if (ql_reg == '0)
            lim_eff = CNT_W'(1);
        else if (32'(ql_reg) > QUEUE_DEPTH)
            lim_eff = CNT_W'(QUEUE_DEPTH);
        else
            lim_eff = CNT_W'(ql_reg);
        if (ad_reg == '0)
            srv_n = DEVN_W'(1);
        else if (32'(ad_reg) > DEVICES)
            srv_n = DEVN_W'(DEVICES);
        else
            srv_n = DEVN_W'(ad_reg);
    end

    always_comb
    begin
        srv_found = 1'b0;
        srv_sel   = '0;
        for (int i = DEVICES - 1; i >= 0; i--)
        begin
            if (!busy_reg[i] && (DEVN_W'(i) < srv_n))
            begin
                srv_found = 1'b1;
                srv_sel   = DEV_W'(i);
            end
        end
    end

    assign n01 = cnt_reg[CLS_CORP] + cnt_reg[CLS_PREM];

    always_comb
    begin
        case (cls_reg)
            CLS_CORP: pos = cnt_reg[CLS_CORP];
            CLS_PREM: pos = n01;
            default:  pos = total_reg;
        endcase
        if (cnt_reg[CLS_CORP] != '0)
            head_cls = CLS_CORP;
        else if (cnt_reg[CLS_PREM] != '0)
            head_cls = CLS_PREM;
        else
            head_cls = CLS_FREE;
    end

    // shared adder: counter increments and wait subtraction
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_cin = 1'b0;
        case (state_reg)
            S_EVICT:
            begin
                alu_a   = rej_reg[ev_cls_reg];
                alu_cin = (alu_a != '1);
            end
            S_REJECT:
            begin
                alu_a   = rej_reg[cls_reg];
                alu_cin = (alu_a != '1);
            end
            S_DISP:
            begin
                alu_a   = now_reg;
                alu_b   = ~tm_reg[0];
                alu_cin = 1'b1;
            end
            S_SERVED:
            begin
                alu_a   = served_reg;
                alu_cin = (alu_a != '1);
            end
            default:
            begin
                alu_a   = '0;
            end
        endcase
        alu_sum = alu_a + alu_b + CTR_W'(alu_cin);
    end

    always_comb
    begin
        state_next  = state_reg;
        total_next  = total_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        rej_next    = rej_reg;
        served_next = served_reg;
        cls_next    = cls_reg;
        ev_cls_next = ev_cls_reg;
        k_next      = k_reg;
        stat_next   = stat_reg;
        evv_next    = evv_reg;
        evid_next   = evid_reg;
        dv_next     = dv_reg;
        did_next    = did_reg;
        ddev_next   = ddev_reg;
        wait_next   = wait_reg;
        do_remove   = 1'b0;
        do_insert   = 1'b0;
        rm_at       = k_reg;
        k_sel       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    evv_next  = 1'b0;
                    evid_next = '0;
                    dv_next   = 1'b0;
                    did_next  = '0;
                    ddev_next = '0;
                    wait_next = '0;
                    cls_next  = (req_class > CLS_FREE) ? CLS_FREE : req_class;
                    if (req_type == REQ_FINISH)
                    begin
                        stat_next = ST_FINISH;
                        for (int i = 0; i < DEVICES; i++)
                        begin
                            if (32'(device_index) == i)
                                busy_next[i] = 1'b0;
                        end
                        state_next = S_DISP;
                    end
                    else
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE:
            begin
                if (total_reg < lim_eff)
                begin
                    stat_next  = ST_QUEUED;
                    state_next = S_INSERT;
                end
                else if ((cls_reg == CLS_CORP || cls_reg == CLS_PREM)
                         && cnt_reg[CLS_FREE] != '0)
                begin
                    k_sel       = n01;
                    k_next      = n01;
                    ev_cls_next = CLS_FREE;
                    evv_next    = 1'b1;
                    evid_next   = id_reg[k_sel[IDX_W-1:0]];
                    stat_next   = ST_EVICTED;
                    state_next  = S_EVICT;
                end
                else if (cls_reg == CLS_CORP && cnt_reg[CLS_PREM] != '0)
                begin
                    k_sel       = cnt_reg[CLS_CORP];
                    k_next      = cnt_reg[CLS_CORP];
                    ev_cls_next = CLS_PREM;
                    evv_next    = 1'b1;
                    evid_next   = id_reg[k_sel[IDX_W-1:0]];
                    stat_next   = ST_EVICTED;
                    state_next  = S_EVICT;
                end
                else
                begin
                    stat_next  = ST_REJECTED;
                    state_next = S_REJECT;
                end
            end
            S_EVICT:
            begin
                do_remove              = 1'b1;
                rm_at                  = k_reg;
                cnt_next[ev_cls_reg]   = cnt_reg[ev_cls_reg] - CNT_W'(1);
                total_next             = total_reg - CNT_W'(1);
                rej_next[ev_cls_reg]   = alu_sum;
                state_next             = S_INSERT;
            end
            S_INSERT:
            begin
                do_insert          = 1'b1;
                cnt_next[cls_reg]  = cnt_reg[cls_reg] + CNT_W'(1);
                total_next         = total_reg + CNT_W'(1);
                state_next         = S_DISP;
            end
            S_REJECT:
            begin
                rej_next[cls_reg] = alu_sum;
                state_next        = S_DONE;
            end
            S_DISP:
            begin
                if (total_reg != '0 && srv_found)
                begin
                    do_remove          = 1'b1;
                    rm_at              = '0;
                    cnt_next[head_cls] = cnt_reg[head_cls] - CNT_W'(1);
                    total_next         = total_reg - CNT_W'(1);
                    for (int i = 0; i < DEVICES; i++)
                    begin
                        if (DEV_W'(i) == srv_sel)
                            busy_next[i] = 1'b1;
                    end
                    dv_next    = 1'b1;
                    did_next   = id_reg[0];
                    ddev_next  = srv_sel;
                    wait_next  = alu_sum;
                    state_next = S_SERVED;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SERVED:
            begin
                served_next = alu_sum;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ad_reg        <= AD_RESET;
            ql_reg        <= QL_RESET;
            total_reg     <= '0;
            cnt_reg       <= '{default: '0};
            busy_reg      <= '0;
            rej_reg       <= '{default: '0};
            served_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            cnt_reg       <= cnt_next;
            busy_reg      <= busy_next;
            rej_reg       <= rej_next;
            served_reg    <= served_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_ACTIVE_DEVICES: ad_reg <= cfg_data[AD_W-1:0];
                    CFG_QUEUE_LIMIT:    ql_reg <= cfg_data[QL_W-1:0];
                    default:            ad_reg <= ad_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg    <= cls_next;
        ev_cls_reg <= ev_cls_next;
        k_reg      <= k_next;
        stat_reg   <= stat_next;
        evv_reg    <= evv_next;
        evid_reg   <= evid_next;
        dv_reg     <= dv_next;
        did_reg    <= did_next;
        ddev_reg   <= ddev_next;
        wait_reg   <= wait_next;
        if (accept)
        begin
            nid_reg <= req_id;
            now_reg <= event_time;
        end
        if (load_out)
        begin
            o_stat_reg   <= stat_reg;
            o_evv_reg    <= evv_reg;
            o_evid_reg   <= evid_reg;
            o_dv_reg     <= dv_reg;
            o_did_reg    <= did_reg;
            o_ddev_reg   <= ddev_reg;
            o_wait_reg   <= wait_reg;
            o_rej_reg    <= rej_reg;
            o_served_reg <= served_reg;
            o_total_reg  <= total_reg;
        end
    end

    // queue cells: shift down on remove, shift up and write on insert
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (do_remove && (CNT_W'(i) >= rm_at) && (i < QUEUE_DEPTH - 1))
            begin
                id_reg[i] <= id_reg[i + 1];
                tm_reg[i] <= tm_reg[i + 1];
            end
            else if (do_insert && (CNT_W'(i) == pos))
            begin
                id_reg[i] <= nid_reg;
                tm_reg[i] <= now_reg;
            end
            else if (do_insert && (CNT_W'(i) > pos) && (i > 0))
            begin
                id_reg[i] <= id_reg[i - 1];
                tm_reg[i] <= tm_reg[i - 1];
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign admit_status       = o_stat_reg;
    assign evicted_valid      = o_evv_reg;
    assign evicted_id         = o_evid_reg;
    assign dispatch_valid     = o_dv_reg;
    assign dispatch_id        = o_did_reg;
    assign dispatch_device    = DEV_OUT_W'(o_ddev_reg);
    assign wait_time          = o_wait_reg;
    assign rejected_corporate = o_rej_reg[CLS_CORP];
    assign rejected_premium   = o_rej_reg[CLS_PREM];
    assign rejected_free      = o_rej_reg[CLS_FREE];
    assign served_count       = o_served_reg;
    assign queue_count        = CNT_OUT_W'(o_total_reg);

endmodule

[design/pbe_checker.sv]
module pbe_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [pbe_pkg::STAT_W-1:0]      admit_status,
    input  logic                            evicted_valid,
    input  logic [pbe_pkg::ID_W-1:0]        evicted_id,
    input  logic                            dispatch_valid,
    input  logic [pbe_pkg::ID_W-1:0]        dispatch_id,
    input  logic [pbe_pkg::DEV_OUT_W-1:0]   dispatch_device,
    input  logic [pbe_pkg::TIME_W-1:0]      wait_time,
    input  logic [pbe_pkg::CTR_W-1:0]       served_count
);

    import pbe_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(admit_status)
            && $stable(dispatch_id) && $stable(wait_time) && $stable(served_count))
        else $error("result word changed while stalled");

    a_evict_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted_valid |-> admit_status == ST_EVICTED)
        else $error("eviction reported without eviction status");

    a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evicted_valid |-> evicted_id == '0)
        else $error("evicted id set without eviction");

    a_disp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !dispatch_valid |-> dispatch_id == '0
            && dispatch_device == '0 && wait_time == '0)
        else $error("dispatch fields set without dispatch");

    a_reject_nodisp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && admit_status == ST_REJECTED |-> !dispatch_valid && !evicted_valid)
        else $error("rejected arrival dispatched or evicted");

endmodule

bind priority_buffer_with_eviction_core pbe_checker u_pbe_checker (.*);

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
    import pbe_pkg::*;

    localparam int Q_SLOTS        = 16;
    localparam int N_SERVERS      = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam cls_t CLS_UNUSED   = 2'd3;

    typedef enum int {STALL_NONE, STALL_SPARSE, STALL_RUNS} stall_mode_t;

    typedef struct packed {
        stat_t                  status;
        logic                   evict_valid;
        logic [ID_W-1:0]        evict_id;
        logic                   disp_valid;
        logic [ID_W-1:0]        disp_id;
        logic [DEV_OUT_W-1:0]   disp_dev;
        logic [TIME_W-1:0]      wait_ticks;
        logic [CTR_W-1:0]       rej_corp;
        logic [CTR_W-1:0]       rej_prem;
        logic [CTR_W-1:0]       rej_free;
        logic [CTR_W-1:0]       served;
        logic [CNT_OUT_W-1:0]   depth;
    } outcome_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   req_type = REQ_ARRIVE;
    logic [CLS_W-1:0]       req_class = CLS_CORP;
    logic [ID_W-1:0]        req_id = '0;
    logic [TIME_W-1:0]      event_time = '0;
    logic [2:0]             device_index = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [STAT_W-1:0]      admit_status;
    logic                   evicted_valid;
    logic [ID_W-1:0]        evicted_id;
    logic                   dispatch_valid;
    logic [ID_W-1:0]        dispatch_id;
    logic [DEV_OUT_W-1:0]   dispatch_device;
    logic [TIME_W-1:0]      wait_time;
    logic [CTR_W-1:0]       rejected_corporate;
    logic [CTR_W-1:0]       rejected_premium;
    logic [CTR_W-1:0]       rejected_free;
    logic [CTR_W-1:0]       served_count;
    logic [CNT_OUT_W-1:0]   queue_count;
    logic                   cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_ACTIVE_DEVICES;
    logic [CFG_W-1:0]       cfg_data = '0;

    // queue and server model
    logic [ID_W-1:0]        q_id [Q_SLOTS];
    cls_t                   q_cls [Q_SLOTS];
    logic [TIME_W-1:0]      q_time [Q_SLOTS];
    int                     q_count = 0;
    bit                     busy [N_SERVERS];
    logic [CTR_W-1:0]       rej_ctr [3];
    logic [CTR_W-1:0]       served_ctr = '0;
    logic [AD_W-1:0]        cfg_devices = AD_RESET;
    logic [QL_W-1:0]        cfg_limit = QL_RESET;

    outcome_t               pending_outcomes [$];
    int                     error_count = 0;
    int                     words_sent = 0;
    int                     results_checked = 0;
    int                     cfg_writes = 0;
    int                     status_seen [4];
    int                     quiet_cycles = 0;
    int                     burst_left = 0;
    bit                     sender_idles = 1'b0;
    stall_mode_t            stall_mode = STALL_NONE;
    int                     stall_hold = 0;
    logic [TIME_W-1:0]      tick_now = '0;

    priority_buffer_with_eviction_core #(
        .QUEUE_DEPTH(Q_SLOTS),
        .DEVICES(N_SERVERS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .req_type(req_type),
        .req_class(req_class),
        .req_id(req_id),
        .event_time(event_time),
        .device_index(device_index),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .admit_status(admit_status),
        .evicted_valid(evicted_valid),
        .evicted_id(evicted_id),
        .dispatch_valid(dispatch_valid),
        .dispatch_id(dispatch_id),
        .dispatch_device(dispatch_device),
        .wait_time(wait_time),
        .rejected_corporate(rejected_corporate),
        .rejected_premium(rejected_premium),
        .rejected_free(rejected_free),
        .served_count(served_count),
        .queue_count(queue_count),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    function automatic logic [CTR_W-1:0] sat_bump(logic [CTR_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic int find_oldest(cls_t c);
        int i;
        for (i = 0; i < q_count; i++)
        begin
            if (q_cls[i] == c)
                return i;
        end
        return -1;
    endfunction

    function automatic void queue_remove(int k);
        int i;
        for (i = k; i + 1 < q_count; i++)
        begin
            q_id[i]   = q_id[i + 1];
            q_cls[i]  = q_cls[i + 1];
            q_time[i] = q_time[i + 1];
        end
        q_count--;
    endfunction

    // insert behind the last entry of the same or higher class
    function automatic void queue_insert(cls_t c, logic [ID_W-1:0] id, logic [TIME_W-1:0] tm);
        int pos;
        int i;
        pos = 0;
        while (pos < q_count && q_cls[pos] <= c)
            pos++;
        for (i = q_count; i > pos; i--)
        begin
            q_id[i]   = q_id[i - 1];
            q_cls[i]  = q_cls[i - 1];
            q_time[i] = q_time[i - 1];
        end
        q_id[pos]   = id;
        q_cls[pos]  = c;
        q_time[pos] = tm;
        q_count++;
    endfunction

    function automatic outcome_t admit_and_dispatch(logic kind, cls_t cls, logic [ID_W-1:0] id,
                                                    logic [TIME_W-1:0] tm, logic [2:0] dev);
        outcome_t r;
        cls_t     c;
        int       k;
        int       lim;
        int       ndev;
        int       i;
        bit       try_disp;
        r = '0;
        try_disp = 1'b0;
        lim  = (cfg_limit == 0) ? 1 : ((cfg_limit > Q_SLOTS) ? Q_SLOTS : int'(cfg_limit));
        ndev = (cfg_devices == 0) ? 1 : ((cfg_devices > N_SERVERS) ? N_SERVERS : int'(cfg_devices));
        if (kind == REQ_ARRIVE)
        begin
            c = (cls == CLS_UNUSED) ? CLS_FREE : cls;
            if (q_count < lim)
            begin
                queue_insert(c, id, tm);
                r.status = ST_QUEUED;
                try_disp = 1'b1;
            end
            else
            begin
                k = -1;
                if (c != CLS_FREE)
                    k = find_oldest(CLS_FREE);
                if (k < 0 && c == CLS_CORP)
                    k = find_oldest(CLS_PREM);
                if (k >= 0)
                begin
                    r.evict_valid = 1'b1;
                    r.evict_id = q_id[k];
                    rej_ctr[q_cls[k]] = sat_bump(rej_ctr[q_cls[k]]);
                    queue_remove(k);
                    queue_insert(c, id, tm);
                    r.status = ST_EVICTED;
                    try_disp = 1'b1;
                end
                else
                begin
                    rej_ctr[c] = sat_bump(rej_ctr[c]);
                    r.status = ST_REJECTED;
                end
            end
        end
        else
        begin
            busy[dev] = 1'b0;
            r.status = ST_FINISH;
            try_disp = 1'b1;
        end
        if (try_disp && q_count > 0)
        begin
            for (i = 0; i < ndev; i++)
            begin
                if (!busy[i])
                begin
                    busy[i] = 1'b1;
                    r.disp_valid = 1'b1;
                    r.disp_id = q_id[0];
                    r.disp_dev = i[DEV_OUT_W-1:0];
                    r.wait_ticks = tm - q_time[0];
                    queue_remove(0);
                    served_ctr = sat_bump(served_ctr);
                    break;
                end
            end
        end
        r.rej_corp = rej_ctr[CLS_CORP];
        r.rej_prem = rej_ctr[CLS_PREM];
        r.rej_free = rej_ctr[CLS_FREE];
        r.served   = served_ctr;
        r.depth    = q_count[CNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic report_error(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_error($sformatf("%s got 0x%0h, want 0x%0h (result %0d)",
                                   name, got, want, results_checked));
    endtask

    task automatic send_word(logic kind, cls_t cls, logic [ID_W-1:0] id,
                             logic [TIME_W-1:0] tm, logic [2:0] dev);
        int gap;
        outcome_t r;
        if (sender_idles)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 9);
                burst_left = $urandom_range(1, 12);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left--;
        end
        in_valid     <= 1'b1;
        req_type     <= kind;
        req_class    <= cls;
        req_id       <= id;
        event_time   <= tm;
        device_index <= dev;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = admit_and_dispatch(kind, cls, id, tm, dev);
        pending_outcomes.insert(pending_outcomes.size(), r);
        status_seen[r.status]++;
        words_sent++;
    endtask

    task automatic drain_and_pause();
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(cfg_idx_t idx, logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_ACTIVE_DEVICES)
            cfg_devices = data[AD_W-1:0];
        else
            cfg_limit = data[QL_W-1:0];
        cfg_writes++;
        @(posedge clk);
    endtask

    task automatic test_directed_cases();
        sender_idles = 1'b0;
        stall_mode = STALL_NONE;
        drain_and_pause();
        write_cfg(CFG_QUEUE_LIMIT, 5'd3);
        send_word(REQ_ARRIVE, CLS_FREE, 16'h0000, 32'd0, 3'd0);
        send_word(REQ_ARRIVE, CLS_FREE, 16'hFFFF, 32'd10, 3'd7);
        send_word(REQ_ARRIVE, CLS_PREM, 16'h1111, 32'd20, 3'd0);
        send_word(REQ_ARRIVE, CLS_CORP, 16'h2222, 32'd30, 3'd0);
        // full: rejects, unused class as free, evictions
        send_word(REQ_ARRIVE, CLS_FREE, 16'h3333, 32'd40, 3'd0);
        send_word(REQ_ARRIVE, CLS_UNUSED, 16'h4444, 32'd50, 3'd0);
        send_word(REQ_ARRIVE, CLS_PREM, 16'h5555, 32'd60, 3'd0);
        send_word(REQ_ARRIVE, CLS_CORP, 16'h6666, 32'd70, 3'd0);
        send_word(REQ_ARRIVE, CLS_PREM, 16'h7777, 32'd80, 3'd0);
        // idle server left waiting through a rejection
        drain_and_pause();
        write_cfg(CFG_ACTIVE_DEVICES, 5'd2);
        send_word(REQ_ARRIVE, CLS_FREE, 16'h8888, 32'd90, 3'd0);
        send_word(REQ_FINISH, CLS_CORP, 16'h0000, 32'd100, 3'd7);
        send_word(REQ_FINISH, CLS_CORP, 16'hFFFF, 32'hFFFF_FFFF, 3'd0);
        send_word(REQ_ARRIVE, CLS_CORP, 16'h9999, 32'd5, 3'd0);
        send_word(REQ_FINISH, CLS_FREE, 16'h0000, 32'hFFFF_FFF0, 3'd1);
        send_word(REQ_FINISH, CLS_FREE, 16'h0000, 32'd3, 3'd0);
        send_word(REQ_FINISH, CLS_FREE, 16'h0000, 32'd4, 3'd0);
    endtask

    task automatic test_limit_lowered();
        sender_idles = 1'b0;
        stall_mode = STALL_SPARSE;
        drain_and_pause();
        write_cfg(CFG_ACTIVE_DEVICES, 5'd1);
        write_cfg(CFG_QUEUE_LIMIT, 5'd31);
        send_word(REQ_ARRIVE, CLS_FREE, 16'hA001, 32'd200, 3'd0);
        send_word(REQ_ARRIVE, CLS_PREM, 16'hA002, 32'd210, 3'd0);
        send_word(REQ_ARRIVE, CLS_FREE, 16'hA003, 32'd220, 3'd0);
        send_word(REQ_ARRIVE, CLS_FREE, 16'hA004, 32'd230, 3'd0);
        drain_and_pause();
        write_cfg(CFG_QUEUE_LIMIT, 5'd0);
        send_word(REQ_ARRIVE, CLS_PREM, 16'hB001, 32'd240, 3'd0);
        send_word(REQ_ARRIVE, CLS_FREE, 16'hB002, 32'd250, 3'd0);
        send_word(REQ_ARRIVE, CLS_CORP, 16'hB003, 32'd260, 3'd0);
        send_word(REQ_ARRIVE, CLS_CORP, 16'hB004, 32'd270, 3'd0);
        send_word(REQ_FINISH, CLS_CORP, 16'h0000, 32'd280, 3'd0);
    endtask

    task automatic test_random_traffic(logic [CFG_W-1:0] devs, logic [CFG_W-1:0] lim, int n,
                                       int arrive_pct, bit idles, stall_mode_t stalls);
        int   busy_list [$];
        int   i;
        logic kind;
        cls_t cls;
        logic [2:0] dev;
        drain_and_pause();
        write_cfg(CFG_ACTIVE_DEVICES, devs);
        write_cfg(CFG_QUEUE_LIMIT, lim);
        sender_idles = idles;
        stall_mode = stalls;
        burst_left = 0;
        repeat (n)
        begin
            if ($urandom_range(0, 31) == 0)
                tick_now = $urandom;
            else
                tick_now = tick_now + $urandom_range(0, 40);
            cls = ($urandom_range(0, 9) == 0) ? CLS_UNUSED : cls_t'($urandom_range(0, 2));
            dev = 3'($urandom_range(0, 7));
            kind = ($urandom_range(0, 99) < arrive_pct) ? REQ_ARRIVE : REQ_FINISH;
            // finish mostly busy servers
            if (kind == REQ_FINISH && $urandom_range(0, 7) != 0)
            begin
                busy_list.delete();
                for (i = 0; i < N_SERVERS; i++)
                begin
                    if (busy[i])
                        busy_list.insert(busy_list.size(), i);
                end
                if (busy_list.size() > 0)
                    dev = 3'(busy_list[$urandom_range(0, busy_list.size() - 1)]);
            end
            send_word(kind, cls, ID_W'($urandom), tick_now, dev);
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_hold != 0)
            stall_hold <= stall_hold - 1;
        else
        begin
            case (stall_mode)
                STALL_NONE:   out_stall <= 1'b0;
                STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
                default:
                begin
                    out_stall  <= ~out_stall;
                    stall_hold <= $urandom_range(0, 6);
                end
            endcase
        end
    end

    always @(posedge clk)
    begin : check_results
        outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_outcomes.size() == 0)
                report_error("result word with nothing pending");
            else
            begin
                want = pending_outcomes[0];
                pending_outcomes.delete(0);
                check_field("admit_status", admit_status, want.status);
                check_field("evicted_valid", evicted_valid, want.evict_valid);
                check_field("evicted_id", evicted_id, want.evict_id);
                check_field("dispatch_valid", dispatch_valid, want.disp_valid);
                check_field("dispatch_id", dispatch_id, want.disp_id);
                check_field("dispatch_device", dispatch_device, want.disp_dev);
                check_field("wait_time", wait_time, want.wait_ticks);
                check_field("rejected_corporate", rejected_corporate, want.rej_corp);
                check_field("rejected_premium", rejected_premium, want.rej_prem);
                check_field("rejected_free", rejected_free, want.rej_free);
                check_field("served_count", served_count, want.served);
                check_field("queue_count", queue_count, want.depth);
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < N_SERVERS; i++)
            busy[i] = 1'b0;
        for (int i = 0; i < 3; i++)
            rej_ctr[i] = '0;
        for (int i = 0; i < 4; i++)
            status_seen[i] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_limit_lowered();
        test_random_traffic(5'd1, 5'd16, 310, 55, 1'b1, STALL_SPARSE);
        test_random_traffic(5'h1F, 5'd31, 310, 70, 1'b0, STALL_NONE);
        test_random_traffic(5'd0, 5'd0, 310, 60, 1'b1, STALL_RUNS);
        test_random_traffic(5'd8, 5'd1, 310, 75, 1'b1, STALL_SPARSE);
        test_random_traffic(5'd3, 5'd5, 310, 65, 1'b1, STALL_RUNS);
        test_random_traffic(5'd2, 5'd16, 310, 80, 1'b0, STALL_SPARSE);

        drain_and_pause();
        repeat (20) @(posedge clk);
        $display("Sent %0d words: %0d queued, %0d with eviction, %0d rejected, %0d finishes",
                 words_sent, status_seen[ST_QUEUED], status_seen[ST_EVICTED],
                 status_seen[ST_REJECTED], status_seen[ST_FINISH]);
        $display("Checked %0d results across %0d register writes, %0d mismatches",
                 results_checked, cfg_writes, error_count);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[sim.f]
design/pbe_pkg.sv
design/priority_buffer_with_eviction_core.sv
design/pbe_checker.sv
test/tb.sv
